/* hdl/fpr_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the framed packet receiver.
// No dependencies; every other file of the block but fpr_ram imports this package.
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int LEN_W       = 7;
    localparam int IDX_W       = 6;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_CRC_POLY    = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hAA;
    localparam logic [CRC_W-1:0]  CRC_POLY_RST    = 16'h1021;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_DEV,
        PH_MSG,
        PH_LENL,
        PH_LENH,
        PH_DATA,
        PH_CRCL,
        PH_CRCH
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [CRC_W-1:0]  crc_polynomial;
    } t_cfg;

    // One checked frame waiting to be played out of its buffer bank.
    typedef struct packed {
        logic [BYTE_W-1:0] device_id;
        logic [BYTE_W-1:0] message_id;
        logic [LEN_W-1:0]  payload_length;
        logic              bank;
    } t_desc;

    typedef struct packed {
        logic [BYTE_W-1:0] device_id;
        logic [BYTE_W-1:0] message_id;
        logic [LEN_W-1:0]  payload_length;
        logic [IDX_W-1:0]  byte_index;
        logic              byte_present;
        logic              last_of_frame;
    } t_emit;

    // MSB-first CRC-16 update by one byte, eight shift steps.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [CRC_W-1:0] poly);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/fpr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/fpr_front.sv */
// Receive side: frame parser, running CRC and payload writes into the buffer RAM.
// Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_front
    import fpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int ADDR_W      = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_room,
    output logic              o_ready,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [BYTE_W-1:0] o_wdata,
    output logic              o_push,
    output t_desc             o_desc
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_dev, n_dev;
    logic [BYTE_W-1:0] r_msg, n_msg;
    logic [BYTE_W-1:0] r_len_lo, n_len_lo;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_crc_lo, n_crc_lo;
    logic              r_bank, n_bank;

    logic              accept;
    logic [CRC_W-1:0]  crc_next;
    logic [15:0]       len_rx;
    logic [CRC_W-1:0]  crc_rx;

    assign o_ready  = i_room;
    assign accept   = i_valid & i_room;
    assign crc_next = crc_feed((r_phase == PH_DEV) ? '0 : r_crc, i_byte, i_cfg.crc_polynomial);
    assign len_rx   = {i_byte, r_len_lo};
    assign crc_rx   = {i_byte, r_crc_lo};

    assign o_wdata = i_byte;
    assign o_waddr = r_bank ? ADDR_W'(MAX_PAYLOAD) + ADDR_W'(r_cnt) : ADDR_W'(r_cnt);
    assign o_desc  = '{device_id: r_dev, message_id: r_msg, payload_length: r_len,
                       bank: r_bank};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_dev    <= '0;
            r_msg    <= '0;
            r_len_lo <= '0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_crc    <= '0;
            r_crc_lo <= '0;
            r_bank   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_dev    <= n_dev;
            r_msg    <= n_msg;
            r_len_lo <= n_len_lo;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
            r_bank   <= n_bank;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_dev    = r_dev;
        n_msg    = r_msg;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        n_bank   = r_bank;
        o_we     = 1'b0;
        o_push   = 1'b0;
        if (accept) begin
            case (r_phase)
                PH_SYNC1: begin
                    if (i_byte == i_cfg.sync_first) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    // A mismatching byte is not retried as a first sync byte.
                    n_phase = (i_byte == i_cfg.sync_second) ? PH_DEV : PH_SYNC1;
                end
                PH_DEV: begin
                    n_dev   = i_byte;
                    n_crc   = crc_next;
                    n_phase = PH_MSG;
                end
                PH_MSG: begin
                    n_msg   = i_byte;
                    n_crc   = crc_next;
                    n_phase = PH_LENL;
                end
                PH_LENL: begin
                    n_len_lo = i_byte;
                    n_crc    = crc_next;
                    n_phase  = PH_LENH;
                end
                PH_LENH: begin
                    n_crc = crc_next;
                    if (len_rx <= 16'(MAX_PAYLOAD)) begin
                        n_len   = LEN_W'(len_rx);
                        n_cnt   = '0;
                        n_phase = (len_rx == 16'd0) ? PH_CRCL : PH_DATA;
                    end else begin
                        n_phase = PH_SYNC1;
                    end
                end
                PH_DATA: begin
                    o_we  = 1'b1;
                    n_crc = crc_next;
                    n_cnt = r_cnt + LEN_W'(1);
                    if (n_cnt >= r_len) begin
                        n_phase = PH_CRCL;
                    end
                end
                PH_CRCL: begin
                    n_crc_lo = i_byte;
                    n_phase  = PH_CRCH;
                end
                PH_CRCH: begin
                    // A good frame hands its bank over and the next frame takes the other one.
                    if (crc_rx == r_crc) begin
                        o_push = 1'b1;
                        n_bank = ~r_bank;
                    end
                    n_phase = PH_SYNC1;
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
    end

endmodule

/* hdl/fpr_queue.sv */
// Two-entry queue of checked frame descriptors between receive and emit sides.
// Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_queue
    import fpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_head,
    output logic  o_has,
    output logic  o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_desc            r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_head = r_entry[r_rp];
    assign o_has  = (r_cnt != '0);
    assign o_full = (r_cnt == CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_desc;
        end
    end

    always_comb begin
        n_wp  = i_push ? r_wp + PTR_W'(1) : r_wp;
        n_rp  = i_pop ? r_rp + PTR_W'(1) : r_rp;
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

endmodule

/* hdl/fpr_back.sv */
// Emit side: walks the head frame's bank, reads the RAM and drives the result channel.
// Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_back
    import fpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64,
    parameter int ADDR_W      = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_desc             i_desc,
    input  logic              i_has,
    output logic              o_pop,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [BYTE_W-1:0] i_rdata,
    output logic              o_valid,
    input  logic              i_ready,
    output t_emit             o_item,
    output logic [BYTE_W-1:0] o_byte
);

    logic [LEN_W-1:0]  r_idx, n_idx;
    logic              r_rd_v, n_rd_v;
    t_emit             r_rd_meta, n_rd_meta;
    logic              r_sk_v, n_sk_v;
    t_emit             r_sk_meta, n_sk_meta;
    logic [BYTE_W-1:0] r_sk_byte, n_sk_byte;
    logic              r_out_v, n_out_v;
    t_emit             r_out_meta, n_out_meta;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;

    logic              out_free;
    logic              issue;
    logic              is_last;
    logic              is_empty;
    logic [BYTE_W-1:0] rd_byte;

    assign o_valid = r_out_v;
    assign o_item  = r_out_meta;
    assign o_byte  = r_out_byte;

    assign out_free = !r_out_v || i_ready;
    assign rd_byte  = r_rd_meta.byte_present ? i_rdata : '0;
    assign is_empty = (i_desc.payload_length == '0);
    assign is_last  = is_empty || ((r_idx + LEN_W'(1)) >= i_desc.payload_length);
    assign o_raddr  = i_desc.bank ? ADDR_W'(MAX_PAYLOAD) + ADDR_W'(r_idx) : ADDR_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
            r_sk_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_rd_v  <= n_rd_v;
            r_sk_v  <= n_sk_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_meta  <= n_rd_meta;
        r_sk_meta  <= n_sk_meta;
        r_sk_byte  <= n_sk_byte;
        r_out_meta <= n_out_meta;
        r_out_byte <= n_out_byte;
    end

    always_comb begin
        n_sk_v     = r_sk_v;
        n_sk_meta  = r_sk_meta;
        n_sk_byte  = r_sk_byte;
        n_out_v    = r_out_v;
        n_out_meta = r_out_meta;
        n_out_byte = r_out_byte;

        // The skid entry is older than the read in flight, so it moves out first.
        if (r_sk_v) begin
            if (out_free) begin
                n_out_v    = 1'b1;
                n_out_meta = r_sk_meta;
                n_out_byte = r_sk_byte;
                if (r_rd_v) begin
                    n_sk_meta = r_rd_meta;
                    n_sk_byte = rd_byte;
                end else begin
                    n_sk_v = 1'b0;
                end
            end
        end else begin
            if (out_free) begin
                n_out_v    = r_rd_v;
                n_out_meta = r_rd_meta;
                n_out_byte = rd_byte;
            end else if (r_rd_v) begin
                n_sk_v    = 1'b1;
                n_sk_meta = r_rd_meta;
                n_sk_byte = rd_byte;
            end
        end

        // A read is only started when its data is sure to find a place next cycle.
        issue  = i_has && !(n_out_v && n_sk_v);
        n_rd_v = issue;
        n_rd_meta = '{device_id: i_desc.device_id, message_id: i_desc.message_id,
                      payload_length: i_desc.payload_length, byte_index: IDX_W'(r_idx),
                      byte_present: !is_empty, last_of_frame: is_last};
        n_idx = r_idx;
        o_pop = 1'b0;
        if (issue) begin
            if (is_last) begin
                n_idx = '0;
                o_pop = 1'b1;
            end else begin
                n_idx = r_idx + LEN_W'(1);
            end
        end
    end

endmodule

/* hdl/framed_packet_receiver_crc16.sv */
// Top level of the framed packet receiver: configuration registers, parser,
// descriptor queue, double-banked payload RAM and emitter. Depends on fpr_pkg,
// fpr_ram, fpr_front, fpr_queue and fpr_back.
//
//   port group    direction  transfer when                 carries
//   rx bytes      in         i_rx_valid & o_rx_ready       i_rx_byte
//   results       out        o_out_valid & i_out_ready     device id .. last_of_frame
//   config (APB)  in         psel & penable & pwrite       sync bytes, CRC polynomial
//
// The parser takes one byte per cycle while o_rx_ready is high; the CRC update of each
// byte is combinational. Results leave at one per cycle while i_out_ready is high once a
// frame passes its CRC, through the registered RAM read and the output register.
// The payload RAM has two banks; with two checked frames still waiting to be played out,
// o_rx_ready drops until the emitter has read the older frame's last byte.
// Reset is synchronous and active low; the RAM needs no clearing pass.
`timescale 1ns / 1ps

module framed_packet_receiver_crc16
    import fpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_device_id,
    output logic [BYTE_W-1:0]     o_message_id,
    output logic [LEN_W-1:0]      o_payload_length,
    output logic [IDX_W-1:0]      o_byte_index,
    output logic [BYTE_W-1:0]     o_payload_byte,
    output logic                  o_byte_present,
    output logic                  o_last_of_frame,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int RAM_DEPTH = 2 * MAX_PAYLOAD;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    t_cfg              r_cfg;
    logic              cfg_write;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              q_push;
    t_desc             q_in;
    logic              q_pop;
    t_desc             q_head;
    logic              q_has;
    logic              q_full;
    t_emit             out_item;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sync_first: SYNC_FIRST_RST, sync_second: SYNC_SECOND_RST,
                       crc_polynomial: CRC_POLY_RST};
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_SYNC_FIRST:  r_cfg.sync_first     <= pwdata[BYTE_W-1:0];
                REG_SYNC_SECOND: r_cfg.sync_second    <= pwdata[BYTE_W-1:0];
                REG_CRC_POLY:    r_cfg.crc_polynomial <= pwdata[CRC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SYNC_FIRST:  prdata = CFG_DATA_W'(r_cfg.sync_first);
            REG_SYNC_SECOND: prdata = CFG_DATA_W'(r_cfg.sync_second);
            REG_CRC_POLY:    prdata = CFG_DATA_W'(r_cfg.crc_polynomial);
            default:         prdata = '0;
        endcase
    end

    fpr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_rx_valid),
        .i_byte  (i_rx_byte),
        .i_room  (!q_full),
        .o_ready (o_rx_ready),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_push  (q_push),
        .o_desc  (q_in)
    );

    fpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_has   (q_has),
        .o_full  (q_full)
    );

    fpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fpr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_desc  (q_head),
        .i_has   (q_has),
        .o_pop   (q_pop),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (out_item),
        .o_byte  (o_payload_byte)
    );

    assign o_device_id      = out_item.device_id;
    assign o_message_id     = out_item.message_id;
    assign o_payload_length = out_item.payload_length;
    assign o_byte_index     = out_item.byte_index;
    assign o_byte_present   = out_item.byte_present;
    assign o_last_of_frame  = out_item.last_of_frame;

endmodule

/* hdl/fpr_checker.sv */
// Port-level checks on the result channel of the framed packet receiver, bound to the top.
// Depends on fpr_pkg and framed_packet_receiver_crc16.
`timescale 1ns / 1ps

module fpr_checker
    import fpr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [LEN_W-1:0]  o_payload_length,
    input logic [IDX_W-1:0]  o_byte_index,
    input logic [BYTE_W-1:0] o_payload_byte,
    input logic              o_byte_present,
    input logic              o_last_of_frame
);

    // A stalled result keeps its payload byte and byte index until the transfer.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_payload_byte)
                                        && $stable(o_byte_index))
        else $error("result changed while stalled");

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An empty frame shows up as a single marker result.
    a_empty_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_present |-> o_last_of_frame && (o_payload_length == '0)
                                           && (o_byte_index == '0))
        else $error("malformed empty-frame result");

    // Last is set exactly on the final payload byte.
    a_last_index : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_present |->
            (LEN_W'(o_byte_index) < o_payload_length)
            && (o_last_of_frame == ((LEN_W'(o_byte_index) + LEN_W'(1)) == o_payload_length)))
        else $error("byte index and last marker disagree");

endmodule

bind framed_packet_receiver_crc16 fpr_checker u_fpr_checker (.*);

/* dv/testbench.sv */
// Self-checking testbench for framed_packet_receiver_crc16: builds sync/header/CRC frames,
// predicts the emitted payload bytes and checks them as they leave the block.
// Depends on fpr_pkg and the RTL of the receiver; nothing else is read.
`timescale 1ns / 1ps

module testbench;
    import fpr_pkg::*;

    localparam int MAX_PAYLOAD = 64;

    typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_SYNC, FR_TOO_LONG} t_frame_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] device_id;
        logic [BYTE_W-1:0] message_id;
        logic [LEN_W-1:0]  payload_length;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_present;
        logic              last_of_frame;
    } t_frame_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_rx_valid = 1'b0;
    logic                  o_rx_ready;
    logic [BYTE_W-1:0]     i_rx_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [BYTE_W-1:0]     o_device_id;
    logic [BYTE_W-1:0]     o_message_id;
    logic [LEN_W-1:0]      o_payload_length;
    logic [IDX_W-1:0]      o_byte_index;
    logic [BYTE_W-1:0]     o_payload_byte;
    logic                  o_byte_present;
    logic                  o_last_of_frame;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    framed_packet_receiver_crc16 #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_rx_valid(i_rx_valid),
        .o_rx_ready(o_rx_ready),
        .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_device_id(o_device_id),
        .o_message_id(o_message_id),
        .o_payload_length(o_payload_length),
        .o_byte_index(o_byte_index),
        .o_payload_byte(o_payload_byte),
        .o_byte_present(o_byte_present),
        .o_last_of_frame(o_last_of_frame),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the configuration registers.
    logic [BYTE_W-1:0] sync_a = SYNC_FIRST_RST;
    logic [BYTE_W-1:0] sync_b = SYNC_SECOND_RST;
    logic [CRC_W-1:0]  crc_gen = CRC_POLY_RST;

    // Parser state of the prediction.
    t_phase            frame_phase = PH_SYNC1;
    logic [BYTE_W-1:0] hold_dev = '0;
    logic [BYTE_W-1:0] hold_msg = '0;
    logic [BYTE_W-1:0] len_lo = '0;
    logic [LEN_W-1:0]  frame_len = '0;
    logic [LEN_W-1:0]  stored_cnt = '0;
    logic [CRC_W-1:0]  crc_acc = '0;
    logic [BYTE_W-1:0] crc_lo = '0;
    logic [BYTE_W-1:0] payload_buf [MAX_PAYLOAD];

    logic [BYTE_W-1:0] rx_stream [$];
    t_frame_byte       frame_bytes_due [$];
    int unsigned       bytes_queued = 0;
    int unsigned       err_count = 0;

    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] acc,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [CRC_W-1:0] gen);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = acc;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            fb = r[CRC_W-1] ^ b[i];
            r = {r[CRC_W-2:0], 1'b0};
            if (fb) begin
                r = r ^ gen;
            end
        end
        return r;
    endfunction

    function void flag_error(input string what);
        err_count++;
        if (err_count <= 10) begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endfunction

    // Advances the parser by one accepted byte and queues the results it releases.
    function void parse_rx_byte(input logic [BYTE_W-1:0] b);
        logic [15:0] len;
        case (frame_phase)
            PH_SYNC1: begin
                if (b == sync_a) frame_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                frame_phase = (b == sync_b) ? PH_DEV : PH_SYNC1;
            end
            PH_DEV: begin
                hold_dev = b;
                crc_acc = crc16_step('0, b, crc_gen);
                frame_phase = PH_MSG;
            end
            PH_MSG: begin
                hold_msg = b;
                crc_acc = crc16_step(crc_acc, b, crc_gen);
                frame_phase = PH_LENL;
            end
            PH_LENL: begin
                len_lo = b;
                crc_acc = crc16_step(crc_acc, b, crc_gen);
                frame_phase = PH_LENH;
            end
            PH_LENH: begin
                len = {b, len_lo};
                crc_acc = crc16_step(crc_acc, b, crc_gen);
                if (len <= MAX_PAYLOAD) begin
                    frame_len = len[LEN_W-1:0];
                    stored_cnt = '0;
                    frame_phase = (len == 0) ? PH_CRCL : PH_DATA;
                end else begin
                    frame_phase = PH_SYNC1;
                end
            end
            PH_DATA: begin
                payload_buf[stored_cnt[IDX_W-1:0]] = b;
                crc_acc = crc16_step(crc_acc, b, crc_gen);
                stored_cnt = stored_cnt + LEN_W'(1);
                if (stored_cnt >= frame_len) frame_phase = PH_CRCL;
            end
            PH_CRCL: begin
                crc_lo = b;
                frame_phase = PH_CRCH;
            end
            PH_CRCH: begin
                if ({b, crc_lo} == crc_acc) begin
                    if (frame_len == 0) begin
                        frame_bytes_due.push_back({hold_dev, hold_msg, LEN_W'(0), IDX_W'(0),
                                                   8'h00, 1'b0, 1'b1});
                    end else begin
                        for (int i = 0; i < frame_len; i++) begin
                            frame_bytes_due.push_back({hold_dev, hold_msg, frame_len,
                                                       IDX_W'(i), payload_buf[i], 1'b1,
                                                       i == frame_len - 1});
                        end
                    end
                end
                frame_phase = PH_SYNC1;
            end
            default: begin
                frame_phase = PH_SYNC1;
            end
        endcase
    endfunction

    function void push_rx(input logic [BYTE_W-1:0] b);
        rx_stream.push_back(b);
        bytes_queued++;
    endfunction

    // Queues one frame; a bad-sync frame puts the first sync byte (its complement if both are
    // equal) in the second slot, then a complete frame body that must still be dropped.
    function void queue_frame(input t_frame_kind kind, input logic [15:0] wire_len,
                              input logic [BYTE_W-1:0] dev, input logic [BYTE_W-1:0] msg);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        crc = crc16_step('0, dev, crc_gen);
        crc = crc16_step(crc, msg, crc_gen);
        crc = crc16_step(crc, wire_len[7:0], crc_gen);
        crc = crc16_step(crc, wire_len[15:8], crc_gen);
        push_rx(sync_a);
        if (kind == FR_BAD_SYNC) push_rx((sync_a != sync_b) ? sync_a : ~sync_b);
        push_rx(sync_b);
        push_rx(dev);
        push_rx(msg);
        push_rx(wire_len[7:0]);
        push_rx(wire_len[15:8]);
        if (kind != FR_TOO_LONG) begin
            for (int i = 0; i < wire_len; i++) begin
                b = BYTE_W'($urandom);
                crc = crc16_step(crc, b, crc_gen);
                push_rx(b);
            end
            if (kind == FR_BAD_CRC) crc ^= 16'($urandom_range(1, 65535));
            push_rx(crc[7:0]);
            push_rx(crc[15:8]);
        end
    endfunction

    // Mostly short payloads; the full buffer only now and then.
    function logic [15:0] pick_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 16'd0;
        if (roll < 90) return 16'($urandom_range(1, 8));
        if (roll < 97) return 16'($urandom_range(9, MAX_PAYLOAD - 1));
        return 16'(MAX_PAYLOAD);
    endfunction

    function void random_traffic(input int unsigned budget);
        int unsigned start_count;
        int unsigned roll;
        logic [15:0] wlen;
        start_count = bytes_queued;
        while (bytes_queued - start_count < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 16) begin
                repeat ($urandom_range(1, 4)) push_rx(BYTE_W'($urandom));
            end else if (roll < 26) begin
                queue_frame(FR_BAD_CRC, pick_len(), BYTE_W'($urandom), BYTE_W'($urandom));
            end else if (roll < 33) begin
                wlen = $urandom_range(0, 1) ? 16'($urandom_range(MAX_PAYLOAD + 1, 255))
                                            : 16'($urandom_range(256, 65535));
                queue_frame(FR_TOO_LONG, wlen, BYTE_W'($urandom), BYTE_W'($urandom));
            end else if (roll < 40) begin
                queue_frame(FR_BAD_SYNC, pick_len(), BYTE_W'($urandom), BYTE_W'($urandom));
            end else begin
                queue_frame(FR_GOOD, pick_len(), BYTE_W'($urandom), BYTE_W'($urandom));
            end
        end
    endfunction

    // Byte driver: a random gap before each byte, with calm stretches of none.
    int unsigned rx_wait = 0;
    bit          rx_wait_set = 1'b0;
    bit          rx_calm = 1'b0;

    always @(posedge i_clk) begin
        logic              nxt_valid;
        logic [BYTE_W-1:0] nxt_byte;
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            nxt_valid = i_rx_valid;
            nxt_byte = i_rx_byte;
            if (i_rx_valid && o_rx_ready) begin
                parse_rx_byte(i_rx_byte);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && rx_stream.size() != 0) begin
                if (!rx_wait_set) begin
                    if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
                    rx_wait = rx_calm ? 0 : $urandom_range(0, 17);
                    rx_wait_set = 1'b1;
                end
                if (rx_wait == 0) begin
                    nxt_valid = 1'b1;
                    nxt_byte = rx_stream.pop_front();
                    rx_wait_set = 1'b0;
                end else begin
                    rx_wait--;
                end
            end
            i_rx_valid <= nxt_valid;
            i_rx_byte <= nxt_byte;
        end
    end

    // Result monitor: checks each transfer, then stalls for a random gap, with calm stretches of none.
    int unsigned out_stall = 0;
    bit          out_calm = 1'b0;

    always @(posedge i_clk) begin
        t_frame_byte got;
        t_frame_byte want;
        if (!i_rst_n) begin
            out_stall = 0;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_device_id, o_message_id, o_payload_length, o_byte_index,
                       o_payload_byte, o_byte_present, o_last_of_frame};
                if (frame_bytes_due.size() == 0) begin
                    flag_error($sformatf("unexpected result dev %h msg %h idx %0d byte %h",
                                         got.device_id, got.message_id, got.byte_index,
                                         got.payload_byte));
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (got !== want) begin
                        flag_error($sformatf({"mismatch: expected dev %h msg %h len %0d ",
                            "idx %0d byte %h present %b last %b, got dev %h msg %h len %0d ",
                            "idx %0d byte %h present %b last %b"},
                            want.device_id, want.message_id, want.payload_length,
                            want.byte_index, want.payload_byte, want.byte_present,
                            want.last_of_frame, got.device_id, got.message_id,
                            got.payload_length, got.byte_index, got.payload_byte,
                            got.byte_present, got.last_of_frame));
                    end
                end
                if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
                out_stall = out_calm ? 0 : $urandom_range(0, 17);
            end else if (out_stall != 0) begin
                out_stall--;
            end
            i_out_ready <= (out_stall == 0);
        end
    end

    task apb_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task set_config(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                    input logic [CRC_W-1:0] poly);
        apb_write(REG_SYNC_FIRST, CFG_DATA_W'(first));
        apb_write(REG_SYNC_SECOND, CFG_DATA_W'(second));
        apb_write(REG_CRC_POLY, CFG_DATA_W'(poly));
        sync_a = first;
        sync_b = second;
        crc_gen = poly;
    endtask

    // Polled on the falling edge so that the clocked blocks have settled.
    task wait_quiet();
        do begin
            @(negedge i_clk);
        end while (rx_stream.size() != 0 || i_rx_valid || frame_bytes_due.size() != 0);
    endtask

    // Holds the sender until every result is out, then walks the parser back to hunting
    // so that a register write never lands in the middle of a frame.
    task settle();
        wait_quiet();
        while (frame_phase != PH_SYNC1) begin
            push_rx((frame_phase == PH_SYNC2) ? ~sync_b : 8'hFF);
            wait_quiet();
        end
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset configuration.
        queue_frame(FR_GOOD, 16'd0, 8'h00, 8'hFF);
        queue_frame(FR_GOOD, 16'd2, 8'hFF, 8'h00);
        queue_frame(FR_BAD_SYNC, 16'd0, 8'h12, 8'h34);
        queue_frame(FR_TOO_LONG, 16'(MAX_PAYLOAD + 1), 8'h56, 8'h78);
        queue_frame(FR_TOO_LONG, 16'h0100, 8'h9A, 8'hBC);
        queue_frame(FR_BAD_CRC, 16'd1, 8'hDE, 8'hF0);
        settle();

        set_config(8'h00, 8'hFF, 16'h0000);
        queue_frame(FR_GOOD, 16'(MAX_PAYLOAD), BYTE_W'($urandom), BYTE_W'($urandom));
        random_traffic(45);
        settle();

        set_config(8'hFF, 8'h00, 16'hFFFF);
        random_traffic(45);
        settle();

        // Equal sync bytes: a repeated first sync byte must not restart the frame.
        set_config(8'h55, 8'h55, 16'h8005);
        random_traffic(35);
        settle();

        set_config(BYTE_W'($urandom), BYTE_W'($urandom), CRC_W'($urandom));
        random_traffic(45);
        settle();

        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
hdl/fpr_pkg.sv
hdl/fpr_ram.sv
hdl/fpr_front.sv
hdl/fpr_queue.sv
hdl/fpr_back.sv
hdl/framed_packet_receiver_crc16.sv
hdl/fpr_checker.sv
dv/testbench.sv
